// ===== sv/tra_pkg.sv =====
// Shared types and constants for the threshold relay alarm controller.
`timescale 1ns / 1ps

package tra_pkg;

   localparam int SAMPLE_W  = 24;
   localparam int COIL_W    = 8;
   localparam int HOLD_W    = 8;
   localparam int RELAY_W   = 4;
   localparam int RETRY_W   = 4;
   localparam int WARM_W    = 16;
   localparam int TIMER_W   = 16;
   localparam int INDEX_W   = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   // input opcodes
   localparam logic [1:0] OP_TICK      = 2'd0;
   localparam logic [1:0] OP_POLL      = 2'd1;
   localparam logic [1:0] OP_READ_RSP  = 2'd2;
   localparam logic [1:0] OP_WRITE_RSP = 2'd3;

   // relay state codes
   localparam logic [1:0] RLY_UNKNOWN   = 2'd0;
   localparam logic [1:0] RLY_RELEASED  = 2'd1;
   localparam logic [1:0] RLY_ENERGIZED = 2'd2;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HOLD      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RELAY     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RETRY     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_WARMUP    = 3'd4;

   // register reset values
   localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 24'd0;
   localparam logic [HOLD_W-1:0]   HOLD_RST      = 8'd1;
   localparam logic [RELAY_W-1:0]  RELAY_RST     = 4'd1;
   localparam logic [RETRY_W-1:0]  RETRY_RST     = 4'd3;
   localparam logic [WARM_W-1:0]   WARMUP_RST    = 16'd60;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [SAMPLE_W-1:0] sample;
      logic [COIL_W-1:0]   coil_bits;
   } req_type;

   typedef struct packed {
      logic               request_kind;
      logic               coil_on;
      logic [INDEX_W-1:0] relay_index;
   } rsp_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] threshold;
      logic [TIMER_W-1:0]  hold_target;
      logic [INDEX_W-1:0]  coil_offset;
      logic [RETRY_W-1:0]  retry_limit;
      logic [WARM_W-1:0]   warmup;
   } cfg_type;

endpackage

// ===== sv/tra_ifs.sv =====
// Valid/ready channel interfaces: request items, response items, register writes.
`timescale 1ns / 1ps

interface tra_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    opcode;
   logic [tra_pkg::SAMPLE_W-1:0]  sample;
   logic [tra_pkg::COIL_W-1:0]    coil_bits;
   modport source (output valid, opcode, sample, coil_bits, input ready);
   modport sink   (input valid, opcode, sample, coil_bits, output ready);
endinterface

interface tra_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         request_kind;
   logic                         coil_on;
   logic [tra_pkg::INDEX_W-1:0]  relay_index;
   modport source (output valid, request_kind, coil_on, relay_index, input ready);
   modport sink   (input valid, request_kind, coil_on, relay_index, output ready);
endinterface

interface tra_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tra_pkg::CSR_ADDR_W-1:0]  addr;
   logic [tra_pkg::CSR_DATA_W-1:0]  wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

// ===== sv/tra_cfg.sv =====
// Configuration registers and derived hold target / coil offset.
`timescale 1ns / 1ps

module tra_cfg #(
   parameter int TICKS_PER_MINUTE = 60
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [tra_pkg::CSR_ADDR_W-1:0]  wr_addr,
   input  logic [tra_pkg::CSR_DATA_W-1:0]  wr_data,
   output tra_pkg::cfg_type                cfg
);

   localparam int TPM_W  = $clog2(TICKS_PER_MINUTE + 1);
   // wide enough for the full product and for the timer-width cap
   localparam int PROD_W = tra_pkg::HOLD_W + tra_pkg::TIMER_W;
   localparam logic [TPM_W-1:0] TPM = TPM_W'(TICKS_PER_MINUTE);

   logic [tra_pkg::SAMPLE_W-1:0] threshold_ff;
   logic [tra_pkg::HOLD_W-1:0]   hold_ff;
   logic [tra_pkg::RELAY_W-1:0]  relay_ff;
   logic [tra_pkg::RETRY_W-1:0]  retry_ff;
   logic [tra_pkg::WARM_W-1:0]   warmup_ff;
   logic [PROD_W-1:0]            hold_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= tra_pkg::THRESHOLD_RST;
         hold_ff      <= tra_pkg::HOLD_RST;
         relay_ff     <= tra_pkg::RELAY_RST;
         retry_ff     <= tra_pkg::RETRY_RST;
         warmup_ff    <= tra_pkg::WARMUP_RST;
      end else if (wr_en) begin
         unique case (wr_addr)
            tra_pkg::CSR_THRESHOLD: threshold_ff <= wr_data[tra_pkg::SAMPLE_W-1:0];
            tra_pkg::CSR_HOLD:      hold_ff      <= wr_data[tra_pkg::HOLD_W-1:0];
            tra_pkg::CSR_RELAY:     relay_ff     <= wr_data[tra_pkg::RELAY_W-1:0];
            tra_pkg::CSR_RETRY:     retry_ff     <= wr_data[tra_pkg::RETRY_W-1:0];
            tra_pkg::CSR_WARMUP:    warmup_ff    <= wr_data[tra_pkg::WARM_W-1:0];
            default: ;
         endcase
      end
   end

   // hold target saturates at the timer width
   assign hold_prod = PROD_W'(hold_ff) * PROD_W'(TPM);

   always_comb begin
      cfg.threshold   = threshold_ff;
      cfg.retry_limit = retry_ff;
      cfg.warmup      = warmup_ff;
      if (hold_prod > PROD_W'({tra_pkg::TIMER_W{1'b1}})) begin
         cfg.hold_target = '1;
      end else begin
         cfg.hold_target = hold_prod[tra_pkg::TIMER_W-1:0];
      end
      // relay 0 maps to the first coil, anything above 8 to the last
      if (relay_ff == '0) begin
         cfg.coil_offset = '0;
      end else if (relay_ff > tra_pkg::RELAY_W'(8)) begin
         cfg.coil_offset = '1;
      end else begin
         cfg.coil_offset = tra_pkg::INDEX_W'(relay_ff - tra_pkg::RELAY_W'(1));
      end
   end

endmodule

// ===== sv/tra_core.sv =====
// Alarm control state: warm-up, level tracking, hold timer, retries, relay state.
`timescale 1ns / 1ps

module tra_core (
   input  logic              clock,
   input  logic              reset,
   input  tra_pkg::cfg_type  cfg,
   input  logic              step,
   input  tra_pkg::req_type  item,
   output logic              emit,
   output tra_pkg::rsp_type  rsp
);

   logic                          alarm_ff,   alarm_in;
   logic                          event_ff,   event_in;
   logic                          fire_ff,    fire_in;
   logic [tra_pkg::TIMER_W-1:0]   timer_ff,   timer_in;
   logic [tra_pkg::RETRY_W-1:0]   retry_ff,   retry_in;
   logic [1:0]                    relay_ff,   relay_in;
   logic                          warm_ff,    warm_in;
   logic [tra_pkg::WARM_W-1:0]    wcnt_ff,    wcnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_ff <= 1'b0;
         event_ff <= 1'b0;
         fire_ff  <= 1'b0;
         timer_ff <= '0;
         retry_ff <= '0;
         relay_ff <= tra_pkg::RLY_UNKNOWN;
         warm_ff  <= 1'b0;
         wcnt_ff  <= '0;
      end else if (step) begin
         alarm_ff <= alarm_in;
         event_ff <= event_in;
         fire_ff  <= fire_in;
         timer_ff <= timer_in;
         retry_ff <= retry_in;
         relay_ff <= relay_in;
         warm_ff  <= warm_in;
         wcnt_ff  <= wcnt_in;
      end
   end

   always_comb begin
      logic run;
      logic level;
      logic coil_bit;

      alarm_in = alarm_ff;
      event_in = event_ff;
      fire_in  = fire_ff;
      timer_in = timer_ff;
      retry_in = retry_ff;
      relay_in = relay_ff;
      warm_in  = warm_ff;
      wcnt_in  = wcnt_ff;
      emit     = 1'b0;
      rsp.request_kind = tra_pkg::REQ_WRITE;
      rsp.coil_on      = 1'b0;
      rsp.relay_index  = cfg.coil_offset;
      run      = 1'b0;
      level    = item.sample > cfg.threshold;
      coil_bit = item.coil_bits[cfg.coil_offset];

      unique case (item.opcode)
         tra_pkg::OP_TICK: begin
            run = 1'b1;
            if (!warm_ff) begin
               if (wcnt_ff >= cfg.warmup) begin
                  warm_in = 1'b1;
               end else begin
                  // counting tick: never used for control
                  wcnt_in = wcnt_ff + 1'b1;
                  if (wcnt_in >= cfg.warmup) warm_in = 1'b1;
                  run = 1'b0;
               end
            end
            if (run) begin
               if (level != alarm_ff) begin
                  alarm_in = level;
                  event_in = 1'b1;
                  timer_in = '0;
               end
               if (event_in) begin
                  if (timer_in != '1) timer_in = timer_in + 1'b1;
                  if (timer_in >= cfg.hold_target) begin
                     timer_in = '0;
                     event_in = 1'b0;
                     fire_in  = 1'b1;
                  end
               end
               if (fire_in) begin
                  if (retry_ff >= cfg.retry_limit) begin
                     fire_in  = 1'b0;
                     retry_in = '0;
                  end else begin
                     retry_in    = retry_ff + 1'b1;
                     emit        = 1'b1;
                     rsp.coil_on = alarm_in;
                     relay_in    = tra_pkg::RLY_UNKNOWN;
                  end
               end
            end
         end
         tra_pkg::OP_POLL: begin
            if (!fire_ff && !event_ff) begin
               emit             = 1'b1;
               rsp.request_kind = tra_pkg::REQ_READ;
               rsp.relay_index  = '0;
               relay_in         = tra_pkg::RLY_UNKNOWN;
            end
         end
         tra_pkg::OP_READ_RSP: begin
            if (!fire_ff && !event_ff) begin
               // corrective write when the coil disagrees with the level
               if ((coil_bit && !alarm_ff && relay_ff != tra_pkg::RLY_RELEASED) ||
                   (!coil_bit && alarm_ff && relay_ff != tra_pkg::RLY_ENERGIZED)) begin
                  emit        = 1'b1;
                  rsp.coil_on = alarm_ff;
                  relay_in    = tra_pkg::RLY_UNKNOWN;
               end
            end
         end
         tra_pkg::OP_WRITE_RSP: begin
            if (!alarm_ff && item.coil_bits == '0) begin
               relay_in = tra_pkg::RLY_RELEASED;
               fire_in  = 1'b0;
               retry_in = '0;
            end else if (alarm_ff && item.coil_bits != '0) begin
               relay_in = tra_pkg::RLY_ENERGIZED;
               fire_in  = 1'b0;
               retry_in = '0;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== sv/threshold_relay_alarm_controller.sv =====
// Top level of the threshold relay alarm controller.
`timescale 1ns / 1ps

// Channel   Modport  Transfer carries
// --------  -------  ----------------------------------------------
// req_ch    sink     opcode, sample, coil_bits (one event per transfer)
// rsp_ch    source   request_kind, coil_on, relay_index (0 or 1 per event)
// csr_ch    sink     addr (register index), wdata; always ready
//
// One event per cycle sustained while rsp_ch does not stall; the req_ch transfer
// fills the event register, and the result register loads from the control logic.
// reset (synchronous) restores register defaults and clears all control state.
// An rsp_ch stall holds the result register; the event register, if empty, still
// takes one more transfer before req_ch.ready drops.

module threshold_relay_alarm_controller #(
   parameter int TICKS_PER_MINUTE = 60
) (
   input  logic          clock,
   input  logic          reset,
   tra_req_if.sink       req_ch,
   tra_rsp_if.source     rsp_ch,
   tra_csr_if.sink       csr_ch
);

   tra_pkg::cfg_type  cfg;
   tra_pkg::req_type  item_ff;
   tra_pkg::rsp_type  rsp_ff;
   tra_pkg::rsp_type  core_rsp;
   logic              item_vld_ff;
   logic              rsp_vld_ff;
   logic              core_emit;
   logic              step;

   assign csr_ch.ready = 1'b1;

   tra_cfg #(
      .TICKS_PER_MINUTE (TICKS_PER_MINUTE)
   ) u_cfg (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_ch.valid),
      .wr_addr (csr_ch.addr),
      .wr_data (csr_ch.wdata),
      .cfg     (cfg)
   );

   // event register advances when the result register is free or draining
   assign step         = item_vld_ff && (!rsp_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !item_vld_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else if (req_ch.ready) begin
         item_vld_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         item_ff.opcode    <= req_ch.opcode;
         item_ff.sample    <= req_ch.sample;
         item_ff.coil_bits <= req_ch.coil_bits;
      end
   end

   tra_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .step  (step),
      .item  (item_ff),
      .emit  (core_emit),
      .rsp   (core_rsp)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (step) begin
         rsp_vld_ff <= core_emit;
      end else if (rsp_ch.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && core_emit) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_ch.valid        = rsp_vld_ff;
   assign rsp_ch.request_kind = rsp_ff.request_kind;
   assign rsp_ch.coil_on      = rsp_ff.coil_on;
   assign rsp_ch.relay_index  = rsp_ff.relay_index;

endmodule
